### design/gapc_pkg.sv
package gapc_pkg;

  localparam logic [1:0] ST_RUN     = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_IDLE    = 2'd3;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_TARGET  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BALLS   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SCORE   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_STOP    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT = 3'd4;

  localparam logic [1:0] REQ_NONE   = 2'd0;
  localparam logic [1:0] REQ_SINGLE = 2'd1;
  localparam logic [1:0] REQ_DOUBLE = 2'd2;

  localparam int HEAD_W      = 16;
  localparam int HRED_W      = 14;
  localparam int TGT_W       = 14;
  localparam int ERR_W       = 15;
  localparam int DCFG_W      = 12;
  localparam int TICK_W      = 16;
  localparam int FWD_W       = 6;
  localparam int SPEED_W     = 16;
  localparam int REQ_W       = 2;
  localparam int STAT_W      = 2;
  localparam int OUT_W       = FWD_W + 2*SPEED_W + REQ_W + STAT_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam int HEADING_MOD = 5760;
  localparam int FWD_SPEED   = 60;
  localparam int KP_TURN     = 3;
  localparam int KD_TURN     = 14;
  localparam int KP_STRAFE   = 5;
  localparam int KD_STRAFE   = 14;
  localparam int KI_STRAFE   = 77;   // 0.3 in Q8
  localparam int ALIGN_LIM   = 160;
  localparam int SUM_WIN     = 64;
  localparam int SUM_DEAD    = 8;
  localparam int FWD_WIN     = 80;
  localparam int FAR_DIST    = 320;

  typedef struct packed {
    logic aligned;
    logic fwd_ok;
  } gapc_ctl_t;

endpackage

### design/gapc_wrap.sv
module gapc_wrap
  import gapc_pkg::*;
(
  input  logic signed [HEAD_W-1:0] heading,
  output logic signed [HRED_W-1:0] heading_red
);

  localparam logic [HEAD_W:0] M4 = (HEAD_W+1)'(4*HEADING_MOD);
  localparam logic [HEAD_W:0] M2 = (HEAD_W+1)'(2*HEADING_MOD);
  localparam logic [HEAD_W:0] M1 = (HEAD_W+1)'(HEADING_MOD);

  logic [HEAD_W:0]   mag;
  logic [HEAD_W:0]   m1;
  logic [HEAD_W:0]   m2;
  logic [HEAD_W:0]   m3;
  logic [HRED_W-1:0] red;

  // truncating remainder: reduce the magnitude, then restore the sign
  always_comb begin
    mag = heading[HEAD_W-1] ? ((HEAD_W+1)'(0) - {heading[HEAD_W-1], heading})
                            : {1'b0, heading};
    m1  = (mag >= M4) ? mag - M4 : mag;
    m2  = (m1 >= M2) ? m1 - M2 : m1;
    m3  = (m2 >= M1) ? m2 - M1 : m2;
    red = m3[HRED_W-1:0];
    heading_red = heading[HEAD_W-1] ? $signed(HRED_W'(0) - red) : $signed(red);
  end

endmodule

### design/gapc_pid.sv
module gapc_pid
  import gapc_pkg::*;
#(
  parameter int DISTANCE_BITS = 12,
  parameter int SUM_BITS      = 24
) (
  input  logic signed [TGT_W-1:0]        target,
  input  logic signed [HRED_W-1:0]       heading_red,
  input  logic [DISTANCE_BITS-1:0]       left,
  input  logic [DISTANCE_BITS-1:0]       right,
  input  logic signed [ERR_W-1:0]        last_head_err,
  input  logic signed [DISTANCE_BITS:0]  last_strafe_err,
  input  logic signed [SUM_BITS-1:0]     err_sum,
  output logic signed [ERR_W-1:0]        head_err,
  output logic signed [DISTANCE_BITS:0]  strafe_err,
  output logic signed [SUM_BITS-1:0]     err_sum_nxt,
  output logic signed [SPEED_W-1:0]      turn,
  output logic signed [SPEED_W-1:0]      strafe,
  output gapc_ctl_t                      ctl
);

  localparam int SE_W = DISTANCE_BITS + 1;
  localparam int TW   = 21;
  localparam int PW   = SUM_BITS + 8;
  localparam int SW   = ((SUM_BITS > 22) ? SUM_BITS : 22) + 2;
  localparam int MW   = 17;

  localparam logic signed [SUM_BITS:0] SUM_HI = (SUM_BITS+1)'((64'sd1 <<< (SUM_BITS-1)) - 1);
  localparam logic signed [SUM_BITS:0] SUM_LO = -SUM_HI - (SUM_BITS+1)'(1);
  localparam logic signed [TW-1:0] T_HI = TW'(32767);
  localparam logic signed [TW-1:0] T_LO = TW'(-32768);
  localparam logic signed [SW-1:0] S_HI = SW'(32767);
  localparam logic signed [SW-1:0] S_LO = SW'(-32768);

  logic [ERR_W-1:0]           abs_e;
  logic [SE_W-1:0]            abs_s;
  logic signed [7:0]          s_small;
  logic signed [SUM_BITS:0]   sum_add;
  logic signed [SUM_BITS-1:0] sum_sat;
  logic signed [TW-1:0]       turn_raw;
  logic signed [PW-1:0]       prod;
  logic signed [SUM_BITS-1:0] integ;
  logic signed [SW-1:0]       strafe_raw;
  logic [DISTANCE_BITS-1:0]   near;
  logic                       in_win;
  logic                       dead;

  always_comb begin
    head_err = ERR_W'(target) - ERR_W'(heading_red);
    abs_e    = head_err[ERR_W-1] ? ERR_W'(0) - head_err : head_err;

    turn_raw = TW'(head_err) * TW'(KP_TURN)
             + (TW'(head_err) - TW'(last_head_err)) * TW'(KD_TURN);
    if (turn_raw > T_HI) turn = SPEED_W'(T_HI);
    else if (turn_raw < T_LO) turn = SPEED_W'(T_LO);
    else turn = turn_raw[SPEED_W-1:0];

    strafe_err = $signed({1'b0, right}) - $signed({1'b0, left});
    abs_s      = strafe_err[SE_W-1] ? SE_W'(0) - strafe_err : strafe_err;
    in_win     = abs_s < SE_W'(SUM_WIN);
    dead       = abs_s < SE_W'(SUM_DEAD);

    // only used inside the window, where the error fits in 8 bits
    s_small = strafe_err[7:0];
    sum_add = (SUM_BITS+1)'(err_sum) + (SUM_BITS+1)'(s_small);
    if (sum_add > SUM_HI) sum_sat = SUM_HI[SUM_BITS-1:0];
    else if (sum_add < SUM_LO) sum_sat = SUM_LO[SUM_BITS-1:0];
    else sum_sat = sum_add[SUM_BITS-1:0];
    err_sum_nxt = (in_win && !dead) ? sum_sat : '0;

    prod  = PW'(err_sum_nxt) * PW'(KI_STRAFE);
    integ = prod[PW-1:8];   // floor toward minus infinity

    strafe_raw = SW'(strafe_err) * SW'(KP_STRAFE)
               + (SW'(strafe_err) - SW'(last_strafe_err)) * SW'(KD_STRAFE)
               + SW'(integ);

    ctl.aligned = abs_e < ERR_W'(ALIGN_LIM);
    if (!ctl.aligned) strafe = '0;
    else if (strafe_raw > S_HI) strafe = SPEED_W'(S_HI);
    else if (strafe_raw < S_LO) strafe = SPEED_W'(S_LO);
    else strafe = strafe_raw[SPEED_W-1:0];

    near       = (left < right) ? left : right;
    ctl.fwd_ok = ctl.aligned &&
                 ((abs_s < SE_W'(FWD_WIN)) || (MW'(near) > MW'(FAR_DIST)));
  end

endmodule

### design/goal_alignment_pid_controller_core.sv
// Goal alignment controller. Each request on the in_ channel is one control tick (or, with
// in_tuser high, the start of a new run) and yields exactly one result on the out_ channel.
// An item is held in the input register and computed into the output register, so a tick is
// taken every cycle unless a result in the output register waits on out_tready; the heading
// reduction and both loops sit in that single stage. A heading PD loop gives turn_speed, a
// strafe PID loop (active only when the heading error is under 10 degrees) gives
// strafe_speed, forward_speed is 0 or 60, and score_request pulses at most once per run. Registers
// are written through cfg_we/cfg_addr/cfg_data and must only change while the block is idle.
module goal_alignment_pid_controller_core
  import gapc_pkg::*;
#(
  parameter int DISTANCE_BITS = 12,
  parameter int SUM_BITS      = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // heading, left_distance, left_valid, right_distance, right_valid, scoring_busy
  input  logic [((19 + 2*DISTANCE_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // command
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // forward_speed, strafe_speed, turn_speed, score_request, status
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int D     = DISTANCE_BITS;
  localparam int IN_W  = 19 + 2*D;
  localparam int CMP_W = (D + 1 > DCFG_W + 1) ? D + 1 : DCFG_W + 1;

  // configuration
  logic signed [TGT_W-1:0] target_r;
  logic [1:0]              balls_r;
  logic [DCFG_W-1:0]       score_dist_r;
  logic [DCFG_W-1:0]       stop_dist_r;
  logic [TICK_W-1:0]       timeout_r;

  // input stage
  logic            in_valid_r;
  logic [IN_W-1:0] in_data_r;
  logic            in_cmd_r;

  // run state
  logic signed [ERR_W-1:0]    last_he_r, last_he_nxt;
  logic signed [D:0]          last_se_r, last_se_nxt;
  logic signed [SUM_BITS-1:0] sum_r, sum_nxt;
  logic [D-1:0]               last_l_r, last_l_nxt;
  logic [D-1:0]               last_r_r, last_r_nxt;
  logic                       started_r, started_nxt;
  logic [TICK_W-1:0]          elapsed_r, elapsed_nxt;
  logic [1:0]                 phase_r, phase_nxt;

  // output stage
  logic                   out_valid_r;
  logic [OUT_W-1:0]       out_data_r, out_data_nxt;

  logic signed [HEAD_W-1:0]   f_heading;
  logic [D-1:0]               f_left, f_right;
  logic                       f_lv, f_rv, f_busy;
  logic [D-1:0]               l_sel, r_sel;
  logic signed [HRED_W-1:0]   heading_red;
  logic signed [ERR_W-1:0]    head_err;
  logic signed [D:0]          strafe_err;
  logic signed [SUM_BITS-1:0] pid_sum_nxt;
  logic signed [SPEED_W-1:0]  pid_turn, pid_strafe;
  gapc_ctl_t                  ctl;

  logic                      advance;
  logic [CMP_W-1:0]          dsum;
  logic [TICK_W:0]           tick_n;
  logic [FWD_W-1:0]          fwd;
  logic signed [SPEED_W-1:0] strafe_o, turn_o;
  logic [REQ_W-1:0]          req;
  logic [STAT_W-1:0]         status;
  logic                      finish;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  assign f_heading = in_data_r[HEAD_W-1:0];
  assign f_left    = in_data_r[HEAD_W +: D];
  assign f_lv      = in_data_r[HEAD_W + D];
  assign f_right   = in_data_r[HEAD_W + D + 1 +: D];
  assign f_rv      = in_data_r[HEAD_W + 2*D + 1];
  assign f_busy    = in_data_r[HEAD_W + 2*D + 2];

  assign l_sel = f_lv ? f_left : last_l_r;
  assign r_sel = f_rv ? f_right : last_r_r;

  gapc_wrap u_wrap (
    .heading     (f_heading),
    .heading_red (heading_red)
  );

  gapc_pid #(
    .DISTANCE_BITS (DISTANCE_BITS),
    .SUM_BITS      (SUM_BITS)
  ) u_pid (
    .target          (target_r),
    .heading_red     (heading_red),
    .left            (l_sel),
    .right           (r_sel),
    .last_head_err   (last_he_r),
    .last_strafe_err (last_se_r),
    .err_sum         (sum_r),
    .head_err        (head_err),
    .strafe_err      (strafe_err),
    .err_sum_nxt     (pid_sum_nxt),
    .turn            (pid_turn),
    .strafe          (pid_strafe),
    .ctl             (ctl)
  );

  always_comb begin
    last_he_nxt = last_he_r;
    last_se_nxt = last_se_r;
    sum_nxt     = sum_r;
    last_l_nxt  = last_l_r;
    last_r_nxt  = last_r_r;
    started_nxt = started_r;
    elapsed_nxt = elapsed_r;
    phase_nxt   = phase_r;
    fwd         = '0;
    strafe_o    = '0;
    turn_o      = '0;
    req         = REQ_NONE;
    status      = phase_r;
    finish      = 1'b0;
    dsum        = CMP_W'(l_sel) + CMP_W'(r_sel);
    tick_n      = {1'b0, elapsed_r} + (TICK_W+1)'(1);

    if (in_cmd_r) begin
      last_he_nxt = '0;
      last_se_nxt = '0;
      sum_nxt     = '0;
      last_l_nxt  = '0;
      last_r_nxt  = '0;
      started_nxt = 1'b0;
      elapsed_nxt = '0;
      phase_nxt   = ST_RUN;
      status      = ST_RUN;
    end else if (phase_r == ST_RUN) begin
      turn_o   = pid_turn;
      strafe_o = pid_strafe;
      sum_nxt  = pid_sum_nxt;
      fwd      = ctl.fwd_ok ? FWD_W'(FWD_SPEED) : '0;
      if (ctl.fwd_ok) begin
        if (dsum < CMP_W'({score_dist_r, 1'b0}) && !started_r) begin
          started_nxt = 1'b1;
          req = (balls_r == REQ_SINGLE || balls_r == REQ_DOUBLE) ? balls_r : REQ_NONE;
        end
        if (dsum < CMP_W'({stop_dist_r, 1'b0})) begin
          fwd      = '0;
          strafe_o = '0;
          turn_o   = '0;
          finish   = !f_busy && started_nxt;
        end
      end
      if (finish) begin
        phase_nxt = ST_DONE;
        status    = ST_DONE;
      end else begin
        last_he_nxt = head_err;
        last_se_nxt = strafe_err;
        last_l_nxt  = l_sel;
        last_r_nxt  = r_sel;
        elapsed_nxt = tick_n[TICK_W] ? '1 : tick_n[TICK_W-1:0];
        if (tick_n > {1'b0, timeout_r}) begin
          phase_nxt = ST_TIMEOUT;
          status    = ST_TIMEOUT;
        end
      end
    end
    out_data_nxt = {status, req, turn_o, strafe_o, fwd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r     <= '0;
      balls_r      <= 2'd1;
      score_dist_r <= DCFG_W'(208);
      stop_dist_r  <= DCFG_W'(184);
      timeout_r    <= TICK_W'(300);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TARGET:  target_r     <= cfg_data[TGT_W-1:0];
        CFG_BALLS:   balls_r      <= cfg_data[1:0];
        CFG_SCORE:   score_dist_r <= cfg_data[DCFG_W-1:0];
        CFG_STOP:    stop_dist_r  <= cfg_data[DCFG_W-1:0];
        CFG_TIMEOUT: timeout_r    <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      last_he_r   <= '0;
      last_se_r   <= '0;
      sum_r       <= '0;
      last_l_r    <= '0;
      last_r_r    <= '0;
      started_r   <= 1'b0;
      elapsed_r   <= '0;
      phase_r     <= ST_IDLE;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (advance) begin
        out_valid_r <= 1'b1;
        last_he_r   <= last_he_nxt;
        last_se_r   <= last_se_nxt;
        sum_r       <= sum_nxt;
        last_l_r    <= last_l_nxt;
        last_r_r    <= last_r_nxt;
        started_r   <= started_nxt;
        elapsed_r   <= elapsed_nxt;
        phase_r     <= phase_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata[IN_W-1:0];
      in_cmd_r  <= in_tuser;
    end
    if (advance) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

  // a start request always leaves the block running
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_cmd_r |=> phase_r == ST_RUN)
    else $error("start request did not enter running phase");

  // a scoring request marks the run as having scored
  a_req_once: assert property (@(posedge clk) disable iff (!rst_n)
    advance && out_data_nxt[OUT_W-STAT_W-1 -: REQ_W] != REQ_NONE |=> started_r)
    else $error("scoring request without started flag");

  // requests never go out while idle
  a_req_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[OUT_W-STAT_W-1 -: REQ_W] != REQ_NONE
      |-> out_data_r[OUT_W-1 -: STAT_W] != ST_IDLE)
    else $error("scoring request outside a running tick");

  a_fwd_values: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r[FWD_W-1:0] == '0 || out_data_r[FWD_W-1:0] == FWD_W'(FWD_SPEED))
    else $error("forward speed out of range");

endmodule

### verif/goal_alignment_pid_controller_core_tb.sv
module goal_alignment_pid_controller_core_tb;
  import gapc_pkg::*;

  localparam int IN_TDATA_W  = ((19 + 2*12 + 7) / 8) * 8;
  localparam int PHASE_ITEMS = 125;
  localparam int NUM_PHASES  = 6;
  localparam int HOLD_CYCLES = 150;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam longint SUM_MAX = (64'sd1 <<< 23) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  typedef struct packed {
    logic               scoring_busy;
    logic               right_valid;
    logic [11:0]        right_distance;
    logic               left_valid;
    logic [11:0]        left_distance;
    logic signed [15:0] heading;
  } tick_t;

  localparam int TICK_T_W = $bits(tick_t);

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         score_request;
    logic signed [15:0] turn_speed;
    logic signed [15:0] strafe_speed;
    logic [5:0]         forward_speed;
  } drive_cmd_t;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] heading;
    logic [11:0]        left;
    logic               lv;
    logic [11:0]        right;
    logic               rv;
    logic               busy;
    logic               lit;
    logic [1:0]         lit_status;
  } dir_row_t;

  typedef struct {
    int target;
    int balls;
    int score;
    int stop;
    int timeout;
  } setup_t;

  localparam int NUM_DIRECTED = 20;
  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    '{1'b0, 16'sd0,     12'd500,  1'b1, 12'd500,  1'b1, 1'b0, 1'b1, ST_IDLE},
    '{1'b1, 16'sd0,     12'd0,    1'b0, 12'd0,    1'b0, 1'b0, 1'b1, ST_RUN},
    '{1'b0, 16'h7fff,   12'd4095, 1'b1, 12'd0,    1'b1, 1'b0, 1'b0, ST_RUN},
    '{1'b0, 16'h8000,   12'd0,    1'b1, 12'd4095, 1'b1, 1'b1, 1'b0, ST_RUN},
    '{1'b0, 16'sd100,   12'd3000, 1'b0, 12'd2000, 1'b0, 1'b0, 1'b0, ST_RUN},
    '{1'b0, 16'sd0,     12'd1000, 1'b1, 12'd1000, 1'b1, 1'b0, 1'b0, ST_RUN},
    '{1'b0, 16'sd0,     12'd1010, 1'b1, 12'd1040, 1'b1, 1'b0, 1'b0, ST_RUN},
    '{1'b0, -16'sd20,   12'd1200, 1'b0, 12'd1060, 1'b1, 1'b0, 1'b0, ST_RUN},
    '{1'b0, 16'sd5760,  12'd400,  1'b1, 12'd700,  1'b1, 1'b0, 1'b0, ST_RUN},
    '{1'b0, -16'sd5761, 12'd300,  1'b1, 12'd360,  1'b1, 1'b0, 1'b0, ST_RUN},
    '{1'b0, 16'sd159,   12'd500,  1'b1, 12'd600,  1'b1, 1'b0, 1'b0, ST_RUN},
    '{1'b0, 16'sd160,   12'd500,  1'b1, 12'd500,  1'b1, 1'b0, 1'b0, ST_RUN},
    '{1'b0, 16'sd0,     12'd200,  1'b1, 12'd204,  1'b1, 1'b1, 1'b0, ST_RUN},
    '{1'b0, 16'sd0,     12'd190,  1'b1, 12'd190,  1'b1, 1'b1, 1'b0, ST_RUN},
    '{1'b0, 16'sd0,     12'd180,  1'b1, 12'd182,  1'b1, 1'b1, 1'b0, ST_RUN},
    '{1'b0, 16'sd0,     12'd180,  1'b1, 12'd182,  1'b1, 1'b0, 1'b0, ST_RUN},
    '{1'b0, 16'sd0,     12'd100,  1'b1, 12'd100,  1'b1, 1'b0, 1'b1, ST_DONE},
    '{1'b1, 16'sd0,     12'd0,    1'b0, 12'd0,    1'b0, 1'b0, 1'b1, ST_RUN},
    '{1'b0, 16'sd0,     12'd150,  1'b1, 12'd150,  1'b1, 1'b0, 1'b0, ST_RUN},
    '{1'b0, 16'sd0,     12'd150,  1'b1, 12'd150,  1'b1, 1'b0, 1'b1, ST_DONE}
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_data;

  goal_alignment_pid_controller_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // controller copy
  logic signed [TGT_W-1:0] cfg_target;
  logic [1:0]              cfg_balls;
  logic [DCFG_W-1:0]       cfg_score_dist;
  logic [DCFG_W-1:0]       cfg_stop_dist;
  logic [TICK_W-1:0]       cfg_timeout;
  longint                  prev_heading_err;
  longint                  prev_strafe_err;
  longint                  strafe_integral;
  longint                  held_left;
  longint                  held_right;
  logic                    shot_requested;
  longint                  tick_count;
  logic [1:0]              run_phase;

  drive_cmd_t drive_q [$];
  int         mismatches = 0;
  int         random_items = 0;
  int         cycle_count = 0;
  int         cur_target = 0;
  bit         random_phase = 1'b0;
  bit         hold_done = 1'b0;
  bit         sender_quiet = 1'b0;

  function automatic longint mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [15:0] sat16(input longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return 16'(v);
  endfunction

  function automatic void clear_history();
    prev_heading_err = 0;
    prev_strafe_err  = 0;
    strafe_integral  = 0;
    held_left        = 0;
    held_right       = 0;
    shot_requested   = 1'b0;
    tick_count       = 0;
  endfunction

  function automatic void reset_model();
    cfg_target     = '0;
    cfg_balls      = REQ_SINGLE;
    cfg_score_dist = 12'd208;
    cfg_stop_dist  = 12'd184;
    cfg_timeout    = 16'd300;
    clear_history();
    run_phase = ST_IDLE;
  endfunction

  function automatic drive_cmd_t predict_drive(input logic cmd, input tick_t t);
    drive_cmd_t r;
    longint hd, e, s, l, rd, dsum, mn, n;
    logic fwd_on, finish;
    r = '0;
    r.status = ST_RUN;
    if (cmd) begin
      clear_history();
      run_phase = ST_RUN;
    end else if (run_phase != ST_RUN) begin
      r.status = run_phase;
    end else begin
      hd = longint'($signed(t.heading)) % HEADING_MOD;
      e = longint'(cfg_target) - hd;
      l = t.left_valid ? longint'(t.left_distance) : held_left;
      rd = t.right_valid ? longint'(t.right_distance) : held_right;
      s = rd - l;
      dsum = l + rd;
      mn = l < rd ? l : rd;
      r.turn_speed = sat16(KP_TURN * e + KD_TURN * (e - prev_heading_err));
      if (mag(s) < SUM_WIN) begin
        strafe_integral = strafe_integral + s;
        if (strafe_integral > SUM_MAX) strafe_integral = SUM_MAX;
        if (strafe_integral < SUM_MIN) strafe_integral = SUM_MIN;
      end else begin
        strafe_integral = 0;
      end
      if (mag(s) < SUM_DEAD) strafe_integral = 0;
      fwd_on = 1'b0;
      if (mag(e) < ALIGN_LIM) begin
        r.strafe_speed = sat16(KP_STRAFE * s + KD_STRAFE * (s - prev_strafe_err) +
                               ((strafe_integral * KI_STRAFE) >>> 8));
        fwd_on = (mag(s) < FWD_WIN) || (mn > FAR_DIST);
      end
      finish = 1'b0;
      if (fwd_on) begin
        if (dsum < 2 * longint'(cfg_score_dist) && !shot_requested) begin
          shot_requested = 1'b1;
          r.score_request = (cfg_balls == REQ_SINGLE || cfg_balls == REQ_DOUBLE) ?
                            cfg_balls : REQ_NONE;
        end
        if (dsum < 2 * longint'(cfg_stop_dist)) begin
          fwd_on = 1'b0;
          r.strafe_speed = '0;
          r.turn_speed = '0;
          finish = !t.scoring_busy && shot_requested;
        end
      end
      r.forward_speed = fwd_on ? 6'(FWD_SPEED) : 6'd0;
      if (finish) begin
        run_phase = ST_DONE;
        r.status = ST_DONE;
      end else begin
        prev_heading_err = e;
        prev_strafe_err = s;
        held_left = l;
        held_right = rd;
        n = tick_count + 1;
        if (n > longint'(cfg_timeout)) begin
          run_phase = ST_TIMEOUT;
          r.status = ST_TIMEOUT;
        end
        tick_count = n > 65535 ? 65535 : n;
      end
    end
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic push_item(input logic cmd, input tick_t t, input logic lit,
                           input logic [1:0] lit_status);
    drive_cmd_t want;
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= IN_TDATA_W'(t);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = predict_drive(cmd, t);
    if (lit) begin
      want = '0;
      want.status = lit_status;
    end
    drive_q.push_back(want);
    if (random_phase) random_items++;
    gap = pick_gap(sender_quiet);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setup(input setup_t su);
    cfg_we   <= 1'b1;
    cfg_addr <= CFG_TARGET;
    cfg_data <= CFG_DATA_W'(su.target);
    @(posedge clk);
    cfg_addr <= CFG_BALLS;
    cfg_data <= CFG_DATA_W'(su.balls);
    @(posedge clk);
    cfg_addr <= CFG_SCORE;
    cfg_data <= CFG_DATA_W'(su.score);
    @(posedge clk);
    cfg_addr <= CFG_STOP;
    cfg_data <= CFG_DATA_W'(su.stop);
    @(posedge clk);
    cfg_addr <= CFG_TIMEOUT;
    cfg_data <= CFG_DATA_W'(su.timeout);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_target     = TGT_W'(su.target);
    cfg_balls      = 2'(su.balls);
    cfg_score_dist = DCFG_W'(su.score);
    cfg_stop_dist  = DCFG_W'(su.stop);
    cfg_timeout    = TICK_W'(su.timeout);
    cur_target     = int'($signed(cfg_target));
  endtask

  function automatic tick_t noise_tick();
    return tick_t'(TICK_T_W'({$urandom, $urandom}));
  endfunction

  function automatic int clamp_dist(input int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  // start, then ticks closing in on the goal until the run ends or the length runs out, then maybe a noise tick
  task automatic drive_run();
    int span, off, len, h, k;
    tick_t t;
    push_item(1'b1, noise_tick(), 1'b0, ST_RUN);
    span = $urandom_range(120, 1400);
    off = int'($urandom_range(0, 200)) - 100;
    len = $urandom_range(3, 50);
    for (k = 0; k < len && run_phase == ST_RUN; k++) begin
      h = cur_target + int'($urandom_range(0, 300)) - 150;
      if ($urandom_range(0, 3) == 0) h = cur_target < 0 ? h - HEADING_MOD : h + HEADING_MOD;
      if ($urandom_range(0, 7) == 0) h = int'($urandom_range(0, 65535));
      if ($urandom_range(0, 9) == 0) off = int'($urandom_range(0, 400)) - 200;
      else off = off + int'($urandom_range(0, 20)) - 10;
      t.heading        = 16'(h);
      t.left_distance  = 12'(clamp_dist(span - off / 2));
      t.right_distance = 12'(clamp_dist(span + off - off / 2));
      t.left_valid     = $urandom_range(0, 7) != 0;
      t.right_valid    = $urandom_range(0, 7) != 0;
      t.scoring_busy   = 1'($urandom_range(0, 1));
      push_item(1'b0, t, 1'b0, ST_RUN);
      span = span - int'($urandom_range(0, 30));
      if (span < 0) span = 0;
    end
    if ($urandom_range(0, 3) == 0) push_item(1'b0, noise_tick(), 1'b0, ST_RUN);
  endtask

  initial begin : stimulus
    setup_t plan [NUM_PHASES];
    tick_t t;
    int i, p, k, sc;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= CFG_TARGET;
    cfg_data  <= '0;
    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < NUM_DIRECTED; i++) begin
      t.heading        = DIRECTED[i].heading;
      t.left_distance  = DIRECTED[i].left;
      t.left_valid     = DIRECTED[i].lv;
      t.right_distance = DIRECTED[i].right;
      t.right_valid    = DIRECTED[i].rv;
      t.scoring_busy   = DIRECTED[i].busy;
      push_item(DIRECTED[i].cmd, t, DIRECTED[i].lit, DIRECTED[i].lit_status);
    end
    drain();

    plan[0] = '{HEADING_MOD, REQ_DOUBLE, 4095, 0, 65535};
    plan[1] = '{-HEADING_MOD, REQ_NONE, 0, 4095, 1};
    plan[2] = '{0, REQ_UNUSED, 208, 184, 40};
    plan[3] = '{1000, REQ_DOUBLE, 300, 250, 60};
    for (p = 4; p < NUM_PHASES; p++) begin
      sc = $urandom_range(100, 600);
      plan[p] = '{int'($urandom_range(0, 2 * HEADING_MOD)) - HEADING_MOD,
                  int'($urandom_range(0, 3)), sc, int'($urandom_range(40, sc)),
                  int'($urandom_range(1, 200))};
    end

    random_phase = 1'b1;
    for (p = 0; p < NUM_PHASES; p++) begin
      apply_setup(plan[p]);
      while (random_items < (p + 1) * PHASE_ITEMS) begin
        sender_quiet = $urandom_range(0, 4) == 0;
        if ($urandom_range(0, 4) != 0) begin
          drive_run();
        end else begin
          for (k = $urandom_range(1, 4); k > 0; k--)
            push_item($urandom_range(0, 3) == 0, noise_tick(), 1'b0, ST_RUN);
        end
      end
      sender_quiet = 1'b0;
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && drive_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned gap;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(0, 9) == 0 ? 60 : $urandom_range(1, 12)) @(posedge clk);
      if (random_phase && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = pick_gap(1'b0);
        if (gap != 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    drive_cmd_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = drive_cmd_t'(out_tdata[OUT_W-1:0]);
      if (drive_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = drive_q.pop_front();
        check_field("forward_speed", want.forward_speed, got.forward_speed);
        check_field("strafe_speed", want.strafe_speed, got.strafe_speed);
        check_field("turn_speed", want.turn_speed, got.turn_speed);
        check_field("score_request", want.score_request, got.score_request);
        check_field("status", want.status, got.status);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
